>>> sv/tmq_pkg.sv
package tmq_pkg;

    localparam int DEFAULT_DEPTH = 16;
    // most timers one tick may remove
    localparam int MAX_OUT = 16;
    localparam int TICK_W = $clog2(MAX_OUT + 1);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_ADJUST = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EXPIRED  = 3'd1,
        ST_NONE     = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_DUP      = 3'd5
    } status_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] handle;
        logic [31:0] expiry;
        logic [31:0] now_time;
    } tmq_in_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] expired_handle;
        logic        last;
    } tmq_out_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] expiry;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic handle_eq;
        logic exp_gt;
    } cmp_t;

endpackage

>>> sv/tmq_ram.sv
module tmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/tmq_cmp.sv
module tmq_cmp
    import tmq_pkg::*;
(
    input  entry_t      entry,
    input  logic [15:0] key_handle,
    input  logic [31:0] key_time,
    output cmp_t        result
);

    assign result.handle_eq = (entry.handle == key_handle);
    assign result.exp_gt    = (entry.expiry > key_time);

endmodule

>>> sv/tmq_seq.sv
module tmq_seq
    import tmq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  tmq_in_t       cmd_data,
    input  entry_t        rd_data,
    input  cmp_t          cmp,
    output logic [15:0]   key_handle,
    output logic [31:0]   key_time,
    input  logic          slot_free,
    output logic          push,
    output tmq_out_t      push_data,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output entry_t        ram_wdata,
    output logic          ram_re,
    output logic [AW-1:0] ram_raddr
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_INS_CHK,
        S_INS_CMP,
        S_TICK_RD,
        S_TICK_CMP,
        S_TICK_FIN,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    tmq_in_t            item_reg, item_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [TICK_W-1:0]  n_reg, n_next;
    logic [15:0]        pend_reg, pend_next;
    logic               have_pend_reg, have_pend_next;
    tmq_out_t           res_reg, res_next;

    logic [CW-1:0]      idx_inc;
    logic [CW-1:0]      idx_dec;
    entry_t             new_entry;

    assign idx_inc = idx_reg + CW'(1);
    assign idx_dec = idx_reg - CW'(1);
    assign new_entry.handle = item_reg.handle;
    assign new_entry.expiry = item_reg.expiry;

    assign key_handle = item_reg.handle;
    assign key_time   = (item_reg.cmd == CMD_TICK) ? item_reg.now_time : item_reg.expiry;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        pend_next      = pend_reg;
        have_pend_next = have_pend_reg;
        res_next       = res_reg;
        cmd_ready      = 1'b0;
        push           = 1'b0;
        push_data      = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[AW-1:0];
        ram_wdata      = rd_data;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    item_next      = cmd_data;
                    idx_next       = '0;
                    n_next         = '0;
                    have_pend_next = 1'b0;
                    state_next     = (cmd_data.cmd == CMD_TICK) ? S_TICK_RD : S_SCAN_RD;
                end
            end

            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (item_reg.cmd == CMD_ADD)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            res_next   = '{status: ST_FULL, expired_handle: '0, last: 1'b1};
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            // free slot sits at the tail, idx already points there
                            state_next = S_INS_CHK;
                        end
                    end
                    else
                    begin
                        res_next   = '{status: ST_NOTFOUND, expired_handle: '0, last: 1'b1};
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                if (cmp.handle_eq)
                begin
                    if (item_reg.cmd == CMD_ADD)
                    begin
                        res_next   = '{status: ST_DUP, expired_handle: '0, last: 1'b1};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_DEL_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end
            end

            // close the gap at idx by pulling the tail down one entry at a time
            S_DEL_RD:
            begin
                if (idx_inc == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    case (item_reg.cmd)
                        CMD_ADJUST:
                        begin
                            idx_next   = count_reg - CW'(1);
                            state_next = S_INS_CHK;
                        end
                        CMD_TICK:
                        begin
                            state_next = S_TICK_RD;
                        end
                        default:
                        begin
                            res_next   = '{status: ST_OK, expired_handle: '0, last: 1'b1};
                            state_next = S_EMIT;
                        end
                    endcase
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_inc[AW-1:0];
                    state_next = S_DEL_WR;
                end
            end

            S_DEL_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = rd_data;
                idx_next   = idx_inc;
                state_next = S_DEL_RD;
            end

            // idx is the open slot; later expiries move up past it
            S_INS_CHK:
            begin
                if (idx_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = new_entry;
                    count_next = count_reg + CW'(1);
                    res_next   = '{status: ST_OK, expired_handle: '0, last: 1'b1};
                    state_next = S_EMIT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_dec[AW-1:0];
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                ram_we = 1'b1;
                if (cmp.exp_gt)
                begin
                    ram_wdata  = rd_data;
                    idx_next   = idx_dec;
                    state_next = S_INS_CHK;
                end
                else
                begin
                    ram_wdata  = new_entry;
                    count_next = count_reg + CW'(1);
                    res_next   = '{status: ST_OK, expired_handle: '0, last: 1'b1};
                    state_next = S_EMIT;
                end
            end

            S_TICK_RD:
            begin
                if (count_reg != '0 && n_reg < TICK_W'(MAX_OUT))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    state_next = S_TICK_CMP;
                end
                else
                begin
                    state_next = S_TICK_FIN;
                end
            end

            // the previous expired handle goes out once another is known due
            S_TICK_CMP:
            begin
                if (!cmp.exp_gt)
                begin
                    if (!have_pend_reg || slot_free)
                    begin
                        push           = have_pend_reg;
                        push_data      = '{status: ST_EXPIRED, expired_handle: pend_reg,
                                           last: 1'b0};
                        pend_next      = rd_data.handle;
                        have_pend_next = 1'b1;
                        n_next         = n_reg + TICK_W'(1);
                        idx_next       = '0;
                        state_next     = S_DEL_RD;
                    end
                end
                else
                begin
                    state_next = S_TICK_FIN;
                end
            end

            S_TICK_FIN:
            begin
                if (have_pend_reg)
                begin
                    res_next = '{status: ST_EXPIRED, expired_handle: pend_reg, last: 1'b1};
                end
                else
                begin
                    res_next = '{status: ST_NONE, expired_handle: '0, last: 1'b1};
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    push       = 1'b1;
                    push_data  = res_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            pend_reg      <= '0;
            have_pend_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            pend_reg      <= pend_next;
            have_pend_reg <= have_pend_next;
            res_reg       <= res_next;
        end
    end

endmodule

>>> sv/sorted_timer_queue_unit.sv
// sorted timer queue: up to DEPTH timers (handle, expiry) kept in ascending
// expiry order in a single-port-write, registered-read table.
// cmd channel (cmd_valid/cmd_ready/cmd_data) takes add, adjust, delete or tick.
// rsp channel (rsp_valid/rsp_ready/rsp_data) returns one status item for add,
// adjust and delete; tick returns one expired item per removed timer (at most
// 16, last set on the final one) or a single nothing-due item.
// every table access is a read followed by a compare or a write, through the
// one handle/expiry comparator; the sequencer walks the table serially.
// add: scans every entry for a duplicate, then walks down from the tail,
// moving later expiries up one slot until the ordered insert point is found.
// delete/adjust: search for the handle, then pull the tail down to close the
// gap; adjust then does the ordered insert walk. tick: each due head is removed.
// cmd_ready is high only between commands; one result waits in the output
// register while the next command is taken, and the sequencer holds when
// rsp_ready is low and the output register is still full.
// reset empties the table at once (count cleared); no clearing pass.
module sorted_timer_queue_unit
    import tmq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  tmq_in_t  cmd_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output tmq_out_t rsp_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    entry_t               rd_data;
    logic [ENTRY_W-1:0]   rd_bits;
    cmp_t                 cmp;
    logic [15:0]          key_handle;
    logic [31:0]          key_time;
    logic                 slot_free;
    logic                 push;
    tmq_out_t             push_data;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    entry_t               ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;

    logic                 rsp_valid_reg, rsp_valid_next;
    tmq_out_t             rsp_data_reg, rsp_data_next;

    tmq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_bits)
    );

    assign rd_data = entry_t'(rd_bits);

    tmq_cmp u_cmp (
        .entry      (rd_data),
        .key_handle (key_handle),
        .key_time   (key_time),
        .result     (cmp)
    );

    tmq_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_data   (cmd_data),
        .rd_data    (rd_data),
        .cmp        (cmp),
        .key_handle (key_handle),
        .key_time   (key_time),
        .slot_free  (slot_free),
        .push       (push),
        .push_data  (push_data),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr)
    );

    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (push)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = push_data;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // a new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!rsp_valid_reg || rsp_ready))
        else $error("result pushed into a full output register");

    // table read and write never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("table read and write in the same cycle");

    // table writes stay inside the configured depth
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({1'b0, ram_waddr} < (AW + 1)'(DEPTH)))
        else $error("table write beyond depth");

    // only expired items carry a handle
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.status != ST_EXPIRED) |-> (push_data.expired_handle == '0))
        else $error("handle on a non-expired result");

endmodule

>>> test/sorted_timer_queue_unit_tb.sv
module sorted_timer_queue_unit_tb import tmq_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH = DEFAULT_DEPTH;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 450;
    // the longest tick (MAX_OUT removals, each a walk over the table) plus slack for the output register
    localparam int SETTLE_CYCLES = (2 * QDEPTH + 3) * MAX_OUT + 64;
    localparam int CYCLE_LIMIT = 1_500_000;

    typedef struct {
        cmd_t        cmd;
        logic [15:0] handle;
        logic [31:0] expiry;
        logic [31:0] now_time;
        bit          typed;
        status_t     st;
    } dir_row_t;

    typedef struct {
        bit      typed;
        status_t st;
    } typed_exp_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    tmq_in_t  cmd_data = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    tmq_out_t rsp_data;

    // shadow copy of the timer list
    logic [15:0] tmr_handle [QDEPTH];
    logic [31:0] tmr_expiry [QDEPTH];
    int          tmr_count = 0;

    tmq_out_t    pending_results[$];
    typed_exp_t  typed_q[$];

    int          mismatches = 0;
    int          n_cmds = 0;
    int          n_results = 0;
    int          n_expired = 0;
    int          n_none = 0;
    int          n_full = 0;
    int          n_dup = 0;
    int          n_notfound = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;
    logic [31:0] clock_base;

    sorted_timer_queue_unit #(
        .DEPTH(QDEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd_data(cmd_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data(rsp_data)
    );

    always #4 clk = ~clk;

    function automatic int find_timer(logic [15:0] h);
        for (int i = 0; i < tmr_count; i++)
        begin
            if (tmr_handle[i] == h)
                return i;
        end
        return -1;
    endfunction

    function automatic void drop_timer(int pos);
        for (int i = pos; i < tmr_count - 1; i++)
        begin
            tmr_handle[i] = tmr_handle[i + 1];
            tmr_expiry[i] = tmr_expiry[i + 1];
        end
        tmr_count--;
    endfunction

    // goes after every timer with equal or earlier expiry
    function automatic void place_timer(logic [15:0] h, logic [31:0] e);
        int pos;
        pos = 0;
        while (pos < tmr_count && tmr_expiry[pos] <= e)
            pos++;
        for (int i = tmr_count; i > pos; i--)
        begin
            tmr_handle[i] = tmr_handle[i - 1];
            tmr_expiry[i] = tmr_expiry[i - 1];
        end
        tmr_handle[pos] = h;
        tmr_expiry[pos] = e;
        tmr_count++;
    endfunction

    function automatic void apply_timer_cmd(input tmq_in_t it, output tmq_out_t outs[$]);
        int pos;
        tmq_out_t r;
        outs = {};
        r = '{status: ST_OK, expired_handle: 16'h0000, last: 1'b1};
        case (it.cmd)
            CMD_ADD:
            begin
                if (find_timer(it.handle) >= 0)
                    r.status = ST_DUP;
                else if (tmr_count >= QDEPTH)
                    r.status = ST_FULL;
                else
                    place_timer(it.handle, it.expiry);
                outs.push_back(r);
            end
            CMD_ADJUST, CMD_DELETE:
            begin
                pos = find_timer(it.handle);
                if (pos < 0)
                    r.status = ST_NOTFOUND;
                else
                begin
                    drop_timer(pos);
                    if (it.cmd == CMD_ADJUST)
                        place_timer(it.handle, it.expiry);
                end
                outs.push_back(r);
            end
            default:
            begin
                while (outs.size() < MAX_OUT && tmr_count > 0 && tmr_expiry[0] <= it.now_time)
                begin
                    r.status = ST_EXPIRED;
                    r.expired_handle = tmr_handle[0];
                    r.last = 1'b0;
                    outs.push_back(r);
                    drop_timer(0);
                end
                if (outs.size() == 0)
                begin
                    r.status = ST_NONE;
                    r.last = 1'b1;
                    outs.push_back(r);
                end
                else
                    outs[outs.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    // mostly live handles and expiries close to a running clock, some noise
    function automatic tmq_in_t make_timer_cmd();
        tmq_in_t it;
        int pick;
        bit use_live;
        it.cmd = cmd_t'($urandom_range(0, 3));
        it.handle = 16'($urandom);
        it.expiry = $urandom;
        it.now_time = $urandom;
        if ($urandom_range(0, 99) < 6)
            return it;
        pick = $urandom_range(0, 99);
        it.cmd = (pick < 40) ? CMD_ADD : (pick < 60) ? CMD_ADJUST :
                 (pick < 72) ? CMD_DELETE : CMD_TICK;
        if (it.cmd == CMD_ADD)
            use_live = $urandom_range(0, 99) < 10;
        else
            use_live = $urandom_range(0, 99) < 80;
        if (use_live && tmr_count > 0)
            it.handle = tmr_handle[$urandom_range(0, tmr_count - 1)];
        else if ($urandom_range(0, 99) < 85)
            it.handle = 16'($urandom_range(0, 47));
        pick = $urandom_range(0, 99);
        if (pick < 6)
            it.expiry = $urandom;
        else if (pick < 8)
            it.expiry = '0;
        else if (pick < 10)
            it.expiry = '1;
        else
            it.expiry = clock_base + $urandom_range(0, 40);
        if (it.cmd == CMD_TICK)
        begin
            clock_base = clock_base + $urandom_range(0, 12);
            pick = $urandom_range(0, 99);
            if (pick < 6)
                it.now_time = $urandom;
            else if (pick < 8)
                it.now_time = '1;
            else
                it.now_time = clock_base;
        end
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_cmd(input tmq_in_t it, input bit typed, input status_t st);
        typed_q.push_back('{typed, st});
        cmd_data <= it;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 99) < 21)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    always @(posedge clk)
        rsp_ready <= quiet || ($urandom_range(0, 99) >= 21);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sorted_timer_queue_unit verification failed");
            $finish;
        end
    end

    // results are checked before the command taken at the same edge is predicted
    always @(posedge clk)
    begin
        tmq_out_t want;
        tmq_out_t outs[$];
        typed_exp_t tx;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                n_results++;
                case (rsp_data.status)
                    ST_EXPIRED:  n_expired++;
                    ST_NONE:     n_none++;
                    ST_FULL:     n_full++;
                    ST_DUP:      n_dup++;
                    ST_NOTFOUND: n_notfound++;
                    default: ;
                endcase
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result status %0d handle %h",
                                              rsp_data.status, rsp_data.expired_handle));
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  rsp_data.status, want.status));
                    if (rsp_data.expired_handle !== want.expired_handle)
                        report_mismatch($sformatf("expired_handle %h, want %h",
                                                  rsp_data.expired_handle, want.expired_handle));
                    if (rsp_data.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b", rsp_data.last, want.last));
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                n_cmds++;
                tx = typed_q.pop_front();
                apply_timer_cmd(cmd_data, outs);
                if (tx.typed)
                    pending_results.push_back('{status: tx.st, expired_handle: 16'h0000,
                                                last: 1'b1});
                else
                    foreach (outs[i])
                        pending_results.push_back(outs[i]);
            end
        end
    end

    initial
    begin
        dir_row_t rows[$];
        tmq_in_t it;
        clock_base = $urandom_range(0, 1000);

        rows.push_back('{CMD_TICK,   16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_NONE});
        rows.push_back('{CMD_DELETE, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_NOTFOUND});
        rows.push_back('{CMD_ADJUST, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_NOTFOUND});
        rows.push_back('{CMD_ADD,    16'h0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_OK});
        rows.push_back('{CMD_ADD,    16'h0000, 32'h0000_0005, 32'h0000_0000, 1'b1, ST_DUP});
        rows.push_back('{CMD_ADD,    16'hFFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK});
        rows.push_back('{CMD_ADD,    16'h0001, 32'd100,       32'h0000_0000, 1'b0, ST_OK});
        // equal expiry keeps arrival order
        rows.push_back('{CMD_ADD,    16'h0002, 32'd100,       32'h0000_0000, 1'b0, ST_OK});
        rows.push_back('{CMD_ADJUST, 16'h0001, 32'd100,       32'h0000_0000, 1'b0, ST_OK});
        // move to an earlier expiry
        rows.push_back('{CMD_ADJUST, 16'h0002, 32'd50,        32'h0000_0000, 1'b0, ST_OK});
        rows.push_back('{CMD_TICK,   16'h0000, 32'h0000_0000, 32'd100,       1'b0, ST_OK});
        for (int i = 1; i < QDEPTH; i++)
            rows.push_back('{CMD_ADD, 16'h0100 + 16'(i), 32'd7, 32'h0000_0000, 1'b0, ST_OK});
        rows.push_back('{CMD_ADD,    16'h0200, 32'd9,         32'h0000_0000, 1'b1, ST_FULL});
        // duplicate wins over full
        rows.push_back('{CMD_ADD,    16'h0105, 32'd9,         32'h0000_0000, 1'b1, ST_DUP});
        // whole table due in one tick
        rows.push_back('{CMD_TICK,   16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ST_OK});
        rows.push_back('{CMD_TICK,   16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_NONE});

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
        begin
            sender_gap();
            it = '{cmd: rows[r].cmd, handle: rows[r].handle, expiry: rows[r].expiry,
                   now_time: rows[r].now_time};
            send_cmd(it, rows[r].typed, rows[r].st);
        end
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet = (i >= 180 && i < 280);
            if (i == 300)
                wait_drained();
            sender_gap();
            send_cmd(make_timer_cmd(), 1'b0, ST_OK);
        end
        quiet = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("covered %0d commands and %0d results: %0d expired, %0d nothing due",
                 n_cmds, n_results, n_expired, n_none);
        $display("status hits: %0d table full, %0d duplicate, %0d unknown handle",
                 n_full, n_dup, n_notfound);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("sorted_timer_queue_unit verification clean");
        else
            $display("sorted_timer_queue_unit verification failed");
        $finish;
    end

endmodule

>>> sorted_timer_queue_unit.f
sv/tmq_pkg.sv
sv/tmq_ram.sv
sv/tmq_cmp.sv
sv/tmq_seq.sv
sv/sorted_timer_queue_unit.sv
test/sorted_timer_queue_unit_tb.sv
